// ===== hdl/flha_pkg.sv =====
// Shared types and constants for the free-list heap allocator.
`default_nettype none
package flha_pkg;
	// Header field selected by a memory write
	typedef enum logic [1:0] {
		FLD_ALL,
		FLD_NEXT,
		FLD_PREV,
		FLD_SIZE
	} hdr_field_t;

	// Write control from the sequencer to the header memory
	typedef struct packed {
		logic       en;
		hdr_field_t field;
	} hdr_wr_t;

	// Result status codes
	localparam logic [1:0] STAT_ALLOC = 2'd0;
	localparam logic [1:0] STAT_OOM   = 2'd1;
	localparam logic [1:0] STAT_FREED = 2'd2;

	// Fixed field widths
	localparam int ADDR_W      = 10;
	localparam int BYTES_W     = 8;
	localparam int STATUS_W    = 2;
	localparam int NEED_W      = 8;
	localparam int RECIP_SHIFT = 16;
endpackage
`default_nettype wire

// ===== hdl/flha_mem.sv =====
// Header memory: next, prev and size per header, field-wise writes, registered read.
`default_nettype none
module flha_mem #(
	parameter int DEPTH = 1025,
	parameter int W     = 11
) (
	input  logic              clk,
	input  flha_pkg::hdr_wr_t wr,
	input  logic [W-1:0]      waddr,
	input  logic [W-1:0]      wnext,
	input  logic [W-1:0]      wprev,
	input  logic [W-1:0]      wsize,
	input  logic [W-1:0]      raddr,
	output logic [W-1:0]      rnext,
	output logic [W-1:0]      rprev,
	output logic [W-1:0]      rsize
);
	import flha_pkg::*;

	typedef struct packed {
		logic [W-1:0] nxt;
		logic [W-1:0] prv;
		logic [W-1:0] sz;
	} hdr_t;

	hdr_t mem_q [DEPTH];
	hdr_t rd_q;

	// Write one field or the whole header; drop writes beyond the store
	always_ff @(posedge clk) begin
		if (wr.en && (32'(waddr) < DEPTH)) begin
			case (wr.field)
				FLD_ALL:  mem_q[waddr]     <= '{nxt: wnext, prv: wprev, sz: wsize};
				FLD_NEXT: mem_q[waddr].nxt <= wnext;
				FLD_PREV: mem_q[waddr].prv <= wprev;
				FLD_SIZE: mem_q[waddr].sz  <= wsize;
				default:  mem_q[waddr].sz  <= wsize;
			endcase
		end
	end

	// Registered read; reads beyond the store give zero
	always_ff @(posedge clk) begin
		if (32'(raddr) < DEPTH) begin
			rd_q <= mem_q[raddr];
		end else begin
			rd_q <= '0;
		end
	end

	assign rnext = rd_q.nxt;
	assign rprev = rd_q.prv;
	assign rsize = rd_q.sz;
endmodule
`default_nettype wire

// ===== hdl/free_list_heap_allocator.sv =====
// Top level: next-fit free-list heap allocator with coalescing on free.
//
//  channel | valid     | stall     | word
//  --------+-----------+-----------+-----------------------------------------
//  request | req_valid | req_stall | mode, request_bytes, block_address
//  result  | rsp_valid | rsp_stall | status, payload_address
//
// Sequencing: one request at a time. The free-list walk reads one header per link,
// limited by the single read port of the header memory. An allocate or a free
// visits L links of the list and then makes 1 to 5 header writes, one after
// another on the single write port.
// Reset: a clearing pass rewrites all ARENA_UNITS + 1 headers;
// req_stall stays high until it ends.
// Stalls: a new request is taken while a result waits; the next result waits
// in its final state until the result register is free.
`default_nettype none
module free_list_heap_allocator #(
	parameter int ARENA_UNITS = 1024,
	parameter int UNIT_BYTES  = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  logic                           mode,
	input  logic [flha_pkg::BYTES_W-1:0]   request_bytes,
	input  logic [flha_pkg::ADDR_W-1:0]    block_address,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output logic [flha_pkg::STATUS_W-1:0]  status,
	output logic [flha_pkg::ADDR_W-1:0]    payload_address
);
	import flha_pkg::*;

	localparam int W          = $clog2(ARENA_UNITS + 1);
	localparam int DEPTH      = ARENA_UNITS + 1;
	localparam int WALK_LIMIT = ARENA_UNITS + 2;
	localparam int WALK_W     = $clog2(WALK_LIMIT);
	localparam int RECIP      = ((1 << RECIP_SHIFT) + UNIT_BYTES - 1) / UNIT_BYTES;
	localparam int PROD_W     = RECIP_SHIFT + 11;
	localparam logic [W-1:0] SENT       = W'(ARENA_UNITS);
	localparam logic [W-1:0] FIRST_SIZE = W'(ARENA_UNITS - 1);
	localparam logic [WALK_W-1:0] WALK_LAST = WALK_W'(WALK_LIMIT - 1);

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_A_ROV,
		ST_A_WALK,
		ST_F_WALK,
		ST_F_BP,
		ST_F_Q,
		ST_WR,
		ST_FIN
	} state_t;

	typedef enum logic [2:0] {
		K_EXACT,
		K_SPLIT,
		K_BOTH,
		K_UPPER,
		K_LOWER,
		K_NEITHER
	} kind_t;

	state_t              state_q;
	kind_t               kind_q;
	logic [2:0]          step_q;
	logic [WALK_W-1:0]   walk_q;
	logic [W-1:0]        clr_q;
	logic [W-1:0]        rover_q;
	logic [NEED_W-1:0]   need_q;
	logic [W-1:0]        p_q;
	logic [W:0]          q_q;
	logic [W-1:0]        bp_q;
	logic [W-1:0]        nx_q;
	logic [W-1:0]        pv_q;
	logic [W-1:0]        szp_q;
	logic [W-1:0]        szbp_q;
	logic [W-1:0]        szq_q;
	logic [W-1:0]        rest_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [ADDR_W-1:0]   res_payload_q;
	logic                rsp_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [ADDR_W-1:0]   payload_q;

	hdr_wr_t      wr;
	logic [W-1:0] raddr;
	logic [W-1:0] rnext;
	logic [W-1:0] rprev;
	logic [W-1:0] rsize;
	logic [W:0]   wr_addr;
	logic [W-1:0] wr_val;
	logic [W-1:0] wnext;
	logic [W-1:0] wprev;
	logic [W-1:0] wsize;
	hdr_field_t   wr_field;
	logic         wr_last;

	logic [9:0]        rnd;
	logic [PROD_W-1:0] prod;
	logic [NEED_W-1:0] need_d;
	logic              addr_bad;
	logic              fits;
	logic              exact;
	logic [W-1:0]      rest_d;
	logic [31:0]       split_addr;
	logic              found;
	logic              upper;
	logic              lower;
	logic [W-1:0]      sum_upper;
	logic [W-1:0]      sum_p_bp;
	logic [W-1:0]      sum_all;
	logic [W-1:0]      need_m;

	// Units needed: ceil(bytes / UNIT_BYTES) + 1 by reciprocal multiply
	assign rnd    = 10'(request_bytes) + 10'(UNIT_BYTES - 1);
	assign prod   = PROD_W'(rnd) * PROD_W'(RECIP);
	assign need_d = NEED_W'(prod >> RECIP_SHIFT) + NEED_W'(1);

	assign addr_bad = (block_address == '0) ||
		((32'(block_address) - 32'd1) >= 32'(ARENA_UNITS));

	// Fit test for the header just read during the allocate walk
	assign fits       = 32'(rsize) >= 32'(need_q);
	assign exact      = 32'(rsize) == 32'(need_q);
	assign rest_d     = W'(32'(rsize) - 32'(need_q));
	assign split_addr = 32'(p_q) + 32'(rest_d);

	// Insertion point test for the free walk
	assign found = ((32'(bp_q) > 32'(p_q)) && (32'(bp_q) < 32'(rnext))) ||
		((32'(p_q) >= 32'(rnext)) &&
		 ((32'(bp_q) > 32'(p_q)) || (32'(bp_q) < 32'(rnext))));

	// Neighbour adjacency
	assign upper = (32'(bp_q) + 32'(szbp_q)) == 32'(q_q);
	assign lower = (32'(p_q) + 32'(szp_q)) == 32'(bp_q);

	assign sum_upper = W'(32'(szbp_q) + 32'(szq_q));
	assign sum_p_bp  = W'(32'(szp_q) + 32'(szbp_q));
	assign sum_all   = W'(32'(szp_q) + 32'(szbp_q) + 32'(szq_q));
	assign need_m    = W'(32'(need_q));

	// Select the read address for the next cycle
	always_comb begin
		case (state_q)
			ST_IDLE:   raddr = rover_q;
			ST_A_ROV:  raddr = rnext;
			ST_A_WALK: raddr = rnext;
			ST_F_WALK: raddr = found ? bp_q : rnext;
			ST_F_BP:   raddr = q_q[W-1:0];
			default:   raddr = rover_q;
		endcase
	end

	// Pick the header write for this step of the update
	always_comb begin
		wr_addr  = (W+1)'(p_q);
		wr_val   = '0;
		wr_field = FLD_SIZE;
		wr_last  = 1'b1;
		case (kind_q)
			K_EXACT: begin
				if (step_q == 3'd0) begin
					wr_addr = (W+1)'(pv_q); wr_field = FLD_NEXT; wr_val = nx_q;
					wr_last = 1'b0;
				end else begin
					wr_addr = (W+1)'(nx_q); wr_field = FLD_PREV; wr_val = pv_q;
				end
			end
			K_SPLIT: begin
				if (step_q == 3'd0) begin
					wr_addr = (W+1)'(p_q); wr_field = FLD_SIZE; wr_val = rest_q;
					wr_last = 1'b0;
				end else begin
					wr_addr = q_q; wr_field = FLD_SIZE; wr_val = need_m;
				end
			end
			K_BOTH: begin
				case (step_q)
					3'd0: begin
						wr_addr = (W+1)'(p_q); wr_field = FLD_SIZE; wr_val = sum_all;
						wr_last = 1'b0;
					end
					3'd1: begin
						wr_addr = (W+1)'(nx_q); wr_field = FLD_PREV; wr_val = p_q;
						wr_last = 1'b0;
					end
					default: begin
						wr_addr = (W+1)'(p_q); wr_field = FLD_NEXT; wr_val = nx_q;
					end
				endcase
			end
			K_UPPER: begin
				case (step_q)
					3'd0: begin
						wr_addr = (W+1)'(bp_q); wr_field = FLD_SIZE; wr_val = sum_upper;
						wr_last = 1'b0;
					end
					3'd1: begin
						wr_addr = (W+1)'(bp_q); wr_field = FLD_NEXT; wr_val = nx_q;
						wr_last = 1'b0;
					end
					3'd2: begin
						wr_addr = (W+1)'(bp_q); wr_field = FLD_PREV; wr_val = pv_q;
						wr_last = 1'b0;
					end
					3'd3: begin
						wr_addr = (W+1)'(nx_q); wr_field = FLD_PREV; wr_val = bp_q;
						wr_last = 1'b0;
					end
					default: begin
						wr_addr = (W+1)'(p_q); wr_field = FLD_NEXT; wr_val = bp_q;
					end
				endcase
			end
			K_LOWER: begin
				wr_addr = (W+1)'(p_q); wr_field = FLD_SIZE; wr_val = sum_p_bp;
			end
			default: begin
				case (step_q)
					3'd0: begin
						wr_addr = (W+1)'(bp_q); wr_field = FLD_NEXT; wr_val = q_q[W-1:0];
						wr_last = 1'b0;
					end
					3'd1: begin
						wr_addr = (W+1)'(bp_q); wr_field = FLD_PREV; wr_val = p_q;
						wr_last = 1'b0;
					end
					3'd2: begin
						wr_addr = q_q; wr_field = FLD_PREV; wr_val = bp_q;
						wr_last = 1'b0;
					end
					default: begin
						wr_addr = (W+1)'(p_q); wr_field = FLD_NEXT; wr_val = bp_q;
					end
				endcase
			end
		endcase
	end

	// Drive the memory write port from the clearing pass or the update steps
	always_comb begin
		wr = '{en: 1'b0, field: FLD_ALL};
		wnext = wr_val;
		wprev = wr_val;
		wsize = wr_val;
		if (state_q == ST_CLR) begin
			wr = '{en: 1'b1, field: FLD_ALL};
			wnext = (clr_q == '0) ? SENT : '0;
			wprev = (clr_q == '0) ? SENT : '0;
			wsize = (clr_q == '0) ? FIRST_SIZE : '0;
		end else if (state_q == ST_WR) begin
			wr = '{en: (32'(wr_addr) <= 32'(ARENA_UNITS)), field: wr_field};
		end
	end

	flha_mem #(
		.DEPTH(DEPTH),
		.W    (W)
	) u_mem (
		.clk  (clk),
		.wr   (wr),
		.waddr(state_q == ST_CLR ? clr_q : wr_addr[W-1:0]),
		.wnext(wnext),
		.wprev(wprev),
		.wsize(wsize),
		.raddr(raddr),
		.rnext(rnext),
		.rprev(rprev),
		.rsize(rsize)
	);

	// Sequencer: clear, walk the list, update headers, hand over the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			rover_q     <= SENT;
			step_q      <= '0;
			walk_q      <= '0;
			kind_q      <= K_NEITHER;
			rsp_valid_q <= 1'b0;
		end else begin
			// Drop the taken result; the final state loads the next one itself
			if (rsp_valid_q && !rsp_stall && (state_q != ST_FIN)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + W'(1);
					if (32'(clr_q) == 32'(ARENA_UNITS)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						walk_q <= '0;
						step_q <= '0;
						if (!mode) begin
							need_q  <= need_d;
							state_q <= ST_A_ROV;
						end else if (addr_bad) begin
							res_status_q  <= STAT_FREED;
							res_payload_q <= '0;
							state_q       <= ST_FIN;
						end else begin
							bp_q    <= W'(32'(block_address) - 32'd1);
							p_q     <= rover_q;
							state_q <= ST_F_WALK;
						end
					end
				end
				ST_A_ROV: begin
					p_q     <= rnext;
					state_q <= ST_A_WALK;
				end
				ST_A_WALK: begin
					if (fits) begin
						rover_q      <= rprev;
						res_status_q <= STAT_ALLOC;
						state_q      <= ST_WR;
						if (exact) begin
							kind_q        <= K_EXACT;
							pv_q          <= rprev;
							nx_q          <= rnext;
							res_payload_q <= ADDR_W'(32'(p_q) + 32'd1);
						end else begin
							kind_q        <= K_SPLIT;
							rest_q        <= rest_d;
							q_q           <= (W+1)'(split_addr);
							res_payload_q <= ADDR_W'(split_addr + 32'd1);
						end
					end else if ((p_q == rover_q) || (walk_q == WALK_LAST)) begin
						res_status_q  <= STAT_OOM;
						res_payload_q <= '0;
						state_q       <= ST_FIN;
					end else begin
						p_q    <= rnext;
						walk_q <= walk_q + WALK_W'(1);
					end
				end
				ST_F_WALK: begin
					if (found) begin
						q_q     <= (W+1)'(rnext);
						szp_q   <= rsize;
						state_q <= ST_F_BP;
					end else if (walk_q == WALK_LAST) begin
						res_status_q  <= STAT_FREED;
						res_payload_q <= '0;
						state_q       <= ST_FIN;
					end else begin
						p_q    <= rnext;
						walk_q <= walk_q + WALK_W'(1);
					end
				end
				ST_F_BP: begin
					szbp_q  <= rsize;
					state_q <= ST_F_Q;
				end
				ST_F_Q: begin
					szq_q         <= rsize;
					nx_q          <= rnext;
					pv_q          <= rprev;
					rover_q       <= p_q;
					res_status_q  <= STAT_FREED;
					res_payload_q <= '0;
					state_q       <= ST_WR;
					if (upper && lower) begin
						kind_q <= K_BOTH;
					end else if (upper) begin
						kind_q <= K_UPPER;
					end else if (lower) begin
						kind_q <= K_LOWER;
					end else begin
						kind_q <= K_NEITHER;
					end
				end
				ST_WR: begin
					step_q <= step_q + 3'd1;
					if (wr_last) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q <= 1'b1;
						status_q    <= res_status_q;
						payload_q   <= res_payload_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req_stall       = (state_q != ST_IDLE);
	assign rsp_valid       = rsp_valid_q;
	assign status          = status_q;
	assign payload_address = payload_q;

	// Headers change only in the clearing pass or the update steps
	a_wr_states: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> ((state_q == ST_WR) || (state_q == ST_CLR)))
		else $error("header write outside update");

	// Walk counter stays within the link limit
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_A_WALK) || (state_q == ST_F_WALK)) |->
		(32'(walk_q) < 32'(WALK_LIMIT)))
		else $error("walk counter beyond limit");

	// Only a successful allocate carries an address
	a_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (status != STAT_ALLOC)) |-> (payload_address == '0))
		else $error("address on a non-allocate result");

	// A result is loaded only when the result register is free
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FIN) && rsp_valid_q && rsp_stall) |=>
		(state_q == ST_FIN))
		else $error("result lost while stalled");
endmodule
`default_nettype wire
